### sv/cgtm_pkg.sv
// ----------------------------------------------------------------------------
// cgtm_pkg
// Shared types, codes and constants of the gesture template matcher.
// ----------------------------------------------------------------------------
package cgtm_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int TEMPLATES   = 8;

  // one lane per candidate template: three hand-game slots, three number slots
  localparam int LANES   = 6;
  localparam int SLOT_W  = $clog2(TEMPLATES);

  // weighted sum: 64x gain adds 6 bits, eight terms add 3 bits
  localparam int WEIGHT_SHIFT = 6;
  localparam int DIST_W       = SAMPLE_BITS + WEIGHT_SHIFT + $clog2(CHANNELS);

  // channels 0, 3, 4, 5 and 7 carry the heavy weight
  localparam logic [CHANNELS-1:0] CHAN_WEIGHTED = 8'b1011_1001;

  // Q0.8 gains and the doubled Q12.4 offset
  localparam logic [7:0] GAIN_FOUR    = 8'd230;
  localparam logic [7:0] GAIN_FIVE    = 8'd102;
  localparam logic [7:0] GAIN_FOUR_B  = 8'd154;
  localparam logic [7:0] OFFSET_TWICE = 8'd224;

  // template slots
  localparam int SLOT_SCISSORS = 0;
  localparam int SLOT_ROCK     = 1;
  localparam int SLOT_PAPER    = 2;
  localparam int SLOT_ONE      = 3;
  localparam int SLOT_TWO      = 4;
  localparam int SLOT_THREE    = 5;
  localparam int SLOT_FOUR     = 6;
  localparam int SLOT_FIVE     = 7;

  typedef logic [SAMPLE_BITS-1:0]          sample_t;
  typedef sample_t [CHANNELS-1:0]          frame_t;
  typedef logic [DIST_W-1:0]               dist_t;
  typedef dist_t [LANES-1:0]               dist_vec_t;

  typedef enum logic [1:0] {
    REQ_STORE  = 2'd0,
    REQ_HAND   = 2'd1,
    REQ_NUMBER = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    GC_TIE      = 4'd0,
    GC_SCISSORS = 4'd1,
    GC_ROCK     = 4'd2,
    GC_PAPER    = 4'd3,
    GC_ONE      = 4'd4,
    GC_TWO      = 4'd5,
    GC_THREE    = 4'd6,
    GC_FOUR     = 4'd7,
    GC_FIVE     = 4'd8
  } gesture_e;

  // single-channel heuristics for number requests
  typedef struct packed {
    logic four;       // channel 0 reaches the four threshold
    logic five;       // channel 7 reaches the five threshold
    logic c5_above;   // channel 5 above the one/two midpoint
    logic c5_below;   // channel 5 below the one/two midpoint
    logic c1_above;   // channel 1 above the two/three midpoint
    logic c3_below;   // channel 3 below the two/three midpoint
  } thresh_flags_t;

endpackage

### sv/capacitive_gesture_template_matcher.sv
// ----------------------------------------------------------------------------
// capacitive_gesture_template_matcher
// Nearest-template gesture classifier over eight capacitance channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries a request type, a template
//   slot and an eight-channel Q12.4 frame. A store transaction writes the
//   frame into the slot and gives no result; a hand-game or number transaction
//   gives one gesture_code on the output channel (out_valid_o / out_stall_i).
//   Request type 3 is dropped without effect.
//   A result passes through the frame register, the lane distance register
//   and the result register. Throughput: one transaction per cycle unless
//   the output stalls; six distance lanes compute all candidate distances
//   for a frame in the same cycle.
//   A store is visible to every transaction accepted after it.
//   Reset clears all templates to zero and empties the pipeline.
//   While the receiver stalls a pending result, the whole pipeline holds and
//   in_stall_o is raised; it drops as soon as the result is taken.
// ----------------------------------------------------------------------------
module capacitive_gesture_template_matcher import cgtm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             req_type_i,
  input  logic [2:0]             template_slot_i,
  input  logic [SAMPLE_BITS-1:0] chan_0_i,
  input  logic [SAMPLE_BITS-1:0] chan_1_i,
  input  logic [SAMPLE_BITS-1:0] chan_2_i,
  input  logic [SAMPLE_BITS-1:0] chan_3_i,
  input  logic [SAMPLE_BITS-1:0] chan_4_i,
  input  logic [SAMPLE_BITS-1:0] chan_5_i,
  input  logic [SAMPLE_BITS-1:0] chan_6_i,
  input  logic [SAMPLE_BITS-1:0] chan_7_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [3:0]             gesture_code_o
);

  logic          advance;
  logic          in_accept;
  logic          is_classify;
  frame_t        frame_in;
  frame_t        tpl_q [TEMPLATES];
  frame_t        x_q;
  logic          s1_valid_q;
  logic          s1_num_q;
  logic          s2_valid_q;
  logic          s2_num_q;
  thresh_flags_t flags_d;
  thresh_flags_t flags_q;
  dist_vec_t     lane_dist;
  gesture_e      code_d;
  gesture_e      code_q;
  logic          out_valid_q;

  // pipeline moves whenever the result register is free or being taken
  assign advance     = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !advance;
  assign in_accept   = in_valid_i && advance;
  assign is_classify = (req_type_i == REQ_HAND) || (req_type_i == REQ_NUMBER);

  assign frame_in = {chan_7_i, chan_6_i, chan_5_i, chan_4_i,
                     chan_3_i, chan_2_i, chan_1_i, chan_0_i};

  // template store, written on store transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TEMPLATES; s++) begin
        tpl_q[s] <= '0;
      end
    end else if (in_accept && req_type_i == REQ_STORE) begin
      tpl_q[template_slot_i[SLOT_W-1:0]] <= frame_in;
    end
  end

  // stage 1: frame register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= frame_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_num_q   <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_accept && is_classify;
      s1_num_q   <= req_type_i == REQ_NUMBER;
    end
  end

  // stage 2: one distance lane per candidate template
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    cgtm_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (advance),
      .frame_i (x_q),
      .tpl_i   (tpl_q[k]),
      .dist_o  (lane_dist[k])
    );
  end

  cgtm_thresh u_thresh (
    .frame_i    (x_q),
    .four_c0_i  (tpl_q[SLOT_FOUR][0]),
    .four_c7_i  (tpl_q[SLOT_FOUR][7]),
    .five_c7_i  (tpl_q[SLOT_FIVE][7]),
    .one_c5_i   (tpl_q[SLOT_ONE][5]),
    .two_c5_i   (tpl_q[SLOT_TWO][5]),
    .two_c1_i   (tpl_q[SLOT_TWO][1]),
    .three_c1_i (tpl_q[SLOT_THREE][1]),
    .two_c3_i   (tpl_q[SLOT_TWO][3]),
    .three_c3_i (tpl_q[SLOT_THREE][3]),
    .flags_o    (flags_d)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_num_q   <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
      s2_num_q   <= s1_num_q;
    end
  end

  // stage 3: merge lanes and flags into the result register
  cgtm_merge u_merge (
    .dist_i      (lane_dist),
    .flags_i     (flags_q),
    .is_number_i (s2_num_q),
    .code_o      (code_d)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q <= code_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign gesture_code_o = code_q;

  // a stored frame lands in its slot
  a_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && req_type_i == REQ_STORE |=>
      tpl_q[$past(template_slot_i)] == $past(frame_in))
    else $error("template store not updated by store transaction");

  // a result only appears after a classify transaction reached stage 2
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_valid_q))
    else $error("result without a classify transaction behind it");

  // hand-game results never carry a number code
  a_hand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s2_valid_q && !s2_num_q |=> code_q <= GC_PAPER)
    else $error("hand-game result out of range");

  // input is held back only by a stalled pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled without a pending result");

endmodule

### sv/cgtm_lane.sv
// ----------------------------------------------------------------------------
// cgtm_lane
// Weighted sum of absolute differences between a frame and one template.
// ----------------------------------------------------------------------------
module cgtm_lane import cgtm_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  frame_t frame_i,
  input  frame_t tpl_i,
  output dist_t  dist_o
);

  dist_t dist_d;
  dist_t dist_q;

  // per-channel absolute difference, heavy channels shifted up, then summed
  always_comb begin
    sample_t diff;
    dist_t   term;
    dist_d = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      diff = (frame_i[c] >= tpl_i[c]) ? (frame_i[c] - tpl_i[c]) : (tpl_i[c] - frame_i[c]);
      term = DIST_W'(diff);
      if (CHAN_WEIGHTED[c]) begin
        term = term << WEIGHT_SHIFT;
      end
      dist_d = dist_d + term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

### sv/cgtm_thresh.sv
// ----------------------------------------------------------------------------
// cgtm_thresh
// Single-channel threshold tests used by number-gesture requests.
// ----------------------------------------------------------------------------
module cgtm_thresh import cgtm_pkg::*; (
  input  frame_t        frame_i,
  input  sample_t       four_c0_i,
  input  sample_t       four_c7_i,
  input  sample_t       five_c7_i,
  input  sample_t       one_c5_i,
  input  sample_t       two_c5_i,
  input  sample_t       two_c1_i,
  input  sample_t       three_c1_i,
  input  sample_t       two_c3_i,
  input  sample_t       three_c3_i,
  output thresh_flags_t flags_o
);

  localparam int PROD_W = SAMPLE_BITS + 8;
  localparam int SUM_W  = SAMPLE_BITS + 9;
  localparam int MID_W  = SAMPLE_BITS + 2;

  logic [PROD_W-1:0] x0_scaled;
  logic [PROD_W-1:0] four_prod;
  logic [PROD_W-1:0] five_prod;
  logic [PROD_W-1:0] four_b_prod;
  logic [SUM_W-1:0]  x7_scaled;
  logic [SUM_W-1:0]  five_sum;
  logic [MID_W-1:0]  off_twice;

  // four/five gain tests, Q0.8 gains against samples scaled by 256
  assign x0_scaled   = {frame_i[0], 8'd0};
  assign four_prod   = PROD_W'(four_c0_i) * PROD_W'(GAIN_FOUR);
  assign five_prod   = PROD_W'(five_c7_i) * PROD_W'(GAIN_FIVE);
  assign four_b_prod = PROD_W'(four_c7_i) * PROD_W'(GAIN_FOUR_B);
  assign x7_scaled   = {1'b0, frame_i[7], 8'd0};
  assign five_sum    = SUM_W'(five_prod) + SUM_W'(four_b_prod);

  assign off_twice = MID_W'(OFFSET_TWICE);

  // midpoint tests, doubled on both sides so no rounding is lost
  always_comb begin
    flags_o.four     = x0_scaled >= four_prod;
    flags_o.five     = x7_scaled >= five_sum;
    flags_o.c5_above = MID_W'({frame_i[5], 1'b0}) >
                       (MID_W'(one_c5_i) + MID_W'(two_c5_i) + off_twice);
    flags_o.c5_below = (MID_W'({frame_i[5], 1'b0}) + off_twice) <
                       (MID_W'(one_c5_i) + MID_W'(two_c5_i));
    flags_o.c1_above = MID_W'({frame_i[1], 1'b0}) >
                       (MID_W'(three_c1_i) + MID_W'(two_c1_i) + off_twice);
    flags_o.c3_below = (MID_W'({frame_i[3], 1'b0}) + off_twice) <
                       (MID_W'(three_c3_i) + MID_W'(two_c3_i));
  end

endmodule

### sv/cgtm_merge.sv
// ----------------------------------------------------------------------------
// cgtm_merge
// Combines lane distances and threshold flags into a gesture code.
// ----------------------------------------------------------------------------
module cgtm_merge import cgtm_pkg::*; (
  input  dist_vec_t     dist_i,
  input  thresh_flags_t flags_i,
  input  logic          is_number_i,
  output gesture_e      code_o
);

  // 1, 2 or 3 for the strictly nearest candidate, 0 on a tie
  function automatic logic [1:0] nearest3(dist_t a, dist_t b, dist_t c);
    logic [1:0] n;
    n = 2'd0;
    if (a < b && a < c) begin
      n = 2'd1;
    end else if (b < a && b < c) begin
      n = 2'd2;
    end else if (c < a && c < b) begin
      n = 2'd3;
    end
    return n;
  endfunction

  logic [1:0] hand_n;
  logic [1:0] num_n;
  gesture_e   hand_code;
  gesture_e   num_code;

  assign hand_n = nearest3(dist_i[SLOT_SCISSORS], dist_i[SLOT_ROCK], dist_i[SLOT_PAPER]);
  assign num_n  = nearest3(dist_i[SLOT_ONE], dist_i[SLOT_TWO], dist_i[SLOT_THREE]);

  // hand game: nearest of scissors, rock, paper
  always_comb begin
    case (hand_n)
      2'd1:    hand_code = GC_SCISSORS;
      2'd2:    hand_code = GC_ROCK;
      2'd3:    hand_code = GC_PAPER;
      default: hand_code = GC_TIE;
    endcase
  end

  // number gesture: four/five test first, then nearest with midpoint fixes
  always_comb begin
    if (flags_i.four) begin
      num_code = flags_i.five ? GC_FIVE : GC_FOUR;
    end else begin
      case (num_n)
        2'd1:    num_code = flags_i.c5_above ? GC_TWO : GC_ONE;
        2'd2: begin
          if (flags_i.c1_above) begin
            num_code = GC_THREE;
          end else if (flags_i.c5_below) begin
            num_code = GC_ONE;
          end else begin
            num_code = GC_TWO;
          end
        end
        2'd3:    num_code = flags_i.c3_below ? GC_TWO : GC_THREE;
        default: num_code = GC_TIE;
      endcase
    end
  end

  assign code_o = is_number_i ? num_code : hand_code;

endmodule
